>>> hdl/seek_steering_step_assert.svh
// assertion macros for the seek steering pipeline
`ifndef SEEK_STEERING_STEP_ASSERT_SVH
`define SEEK_STEERING_STEP_ASSERT_SVH

// a condition that must hold at every clock edge outside reset
`define SSS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// an antecedent that implies a consequent in the next cycle
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/sss_pkg.sv
// package: constants and types for the seek steering pipeline
`timescale 1ns / 1ps
package sss_pkg;

  localparam int unsigned IdxW   = 16;
  localparam int unsigned PosW   = 32;
  localparam int unsigned SpdW   = 31;
  localparam int unsigned StepW  = 20;
  localparam int unsigned DeltaW = 33;
  localparam int unsigned MagW   = 32;
  localparam int unsigned SqW    = 64;
  localparam int unsigned SumW   = 66;
  localparam int unsigned RootW  = 33;
  localparam int unsigned RemW   = 35;
  localparam int unsigned ProdW  = 63;
  localparam int unsigned TravW  = 51;
  localparam int unsigned QuoW   = 63;
  localparam int unsigned RootSteps = 33;
  localparam int unsigned DivSteps  = 63;
  localparam logic [StepW-1:0] StepTimeReset = StepW'(1092);

  typedef struct packed {
    logic [IdxW-1:0]        entity_index;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [PosW-1:0] target_x;
    logic signed [PosW-1:0] target_y;
    logic signed [PosW-1:0] target_z;
    logic [SpdW-1:0]        speed;
    logic [SpdW-1:0]        snap_radius;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]        out_entity_index;
    logic                   arrived;
    logic signed [PosW-1:0] new_pos_x;
    logic signed [PosW-1:0] new_pos_y;
    logic signed [PosW-1:0] new_pos_z;
    logic signed [PosW-1:0] vel_x;
    logic signed [PosW-1:0] vel_y;
    logic signed [PosW-1:0] vel_z;
  } out_item_t;

  // item state carried between the front and the back of the pipeline
  typedef struct packed {
    logic [IdxW-1:0]        entity_index;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [PosW-1:0] target_x;
    logic signed [PosW-1:0] target_y;
    logic signed [PosW-1:0] target_z;
    logic [SpdW-1:0]        speed;
    logic [SpdW-1:0]        snap_radius;
    logic [MagW-1:0]        mag_x;
    logic [MagW-1:0]        mag_y;
    logic [MagW-1:0]        mag_z;
    logic                   neg_x;
    logic                   neg_y;
    logic                   neg_z;
    logic [TravW-1:0]       travel;
  } carry_t;

  // pipeline flow control shared by the stages
  typedef struct packed {
    logic adv;
  } flow_t;

endpackage

>>> hdl/sss_stream_if.sv
// valid/ready channel interfaces for items and configuration
`timescale 1ns / 1ps
interface sss_in_if;
  import sss_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sss_out_if;
  import sss_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sss_cfg_if;
  import sss_pkg::*;
  logic             valid;
  logic             ready;
  logic [StepW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/sss_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module sss_sqrt_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sss_pkg::flow_t            flow_i,
  input  logic                      valid_i,
  input  logic [sss_pkg::SumW-1:0]  sum_i,
  input  sss_pkg::carry_t           carry_i,
  output logic                      valid_o,
  output logic [sss_pkg::RootW-1:0] root_o,
  output sss_pkg::carry_t           carry_o
);
  import sss_pkg::*;

  logic                           vld_q  [RootSteps+1];
  logic [SumW-1:0]                sum_q  [RootSteps+1];
  logic [RootW-1:0]               root_q [RootSteps+1];
  logic [RemW-1:0]                rem_q  [RootSteps+1];
  carry_t                         car_q  [RootSteps+1];

  always_comb begin
    sum_q[0]  = sum_i;
    root_q[0] = '0;
    rem_q[0]  = '0;
    car_q[0]  = carry_i;
    vld_q[0]  = valid_i;
  end

  for (genvar s = 0; s < RootSteps; s++) begin : g_step
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic [SumW-1:0]  sum_d;
    logic [RootW-1:0] root_d;
    logic [RemW-1:0]  rem_d;
    always_comb begin
      rem_sh = {rem_q[s][RemW-3:0], sum_q[s][SumW-1 -: 2]};
      trial  = {root_q[s][RemW-3:0], 2'b01};
      sum_d  = {sum_q[s][SumW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[s][RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[s][RootW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (flow_i.adv) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (flow_i.adv) begin
        sum_q[s+1]  <= sum_d;
        root_q[s+1] <= root_d;
        rem_q[s+1]  <= rem_d;
        car_q[s+1]  <= car_q[s];
      end
    end
  end

  assign valid_o = vld_q[RootSteps];
  assign root_o  = root_q[RootSteps];
  assign carry_o = car_q[RootSteps];
endmodule

>>> hdl/sss_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module sss_div_pipe (
  input  logic                      clk_i,
  input  sss_pkg::flow_t            flow_i,
  input  logic [sss_pkg::ProdW-1:0] num_i,
  input  logic [sss_pkg::RootW-1:0] den_i,
  output logic [sss_pkg::QuoW-1:0]  quo_o
);
  import sss_pkg::*;

  localparam int unsigned RW = RootW + 1;

  logic [ProdW-1:0] num_q [DivSteps+1];
  logic [RootW-1:0] den_q [DivSteps+1];
  logic [RW-1:0]    rem_q [DivSteps+1];

  always_comb begin
    num_q[0] = num_i;
    den_q[0] = den_i;
    rem_q[0] = '0;
  end

  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    logic [RW-1:0]    sh;
    logic [RW-1:0]    rem_d;
    logic [ProdW-1:0] num_d;
    always_comb begin
      sh = {rem_q[s][RW-2:0], num_q[s][ProdW-1]};
      if (sh >= {1'b0, den_q[s]}) begin
        rem_d = sh - {1'b0, den_q[s]};
        num_d = {num_q[s][ProdW-2:0], 1'b1};
      end else begin
        rem_d = sh;
        num_d = {num_q[s][ProdW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (flow_i.adv) begin
        num_q[s+1] <= num_d;
        den_q[s+1] <= den_q[s];
        rem_q[s+1] <= rem_d;
      end
    end
  end

  assign quo_o = num_q[DivSteps];
endmodule

>>> hdl/seek_steering_step.sv
// top level: seek steering step pipeline with arrival snap
//
// channel  dir  handshake      payload
// in_s     in   valid/ready    entity, position, target, speed, radius
// out_m    out  valid/ready    entity, arrived, new position, velocity
// cfg_s    in   valid/ready    step_time (Q4.16)
//
// one item per cycle while the output is not stalled; the pipeline depth is set
// by the bit-per-stage square root (33 stages) and divider (63 stages)
// the whole pipeline advances together; it holds when the output register
// is full and not taken, so a stall loses and repeats nothing
// reset clears the valid bits and loads step_time with 1092
`timescale 1ns / 1ps
`include "seek_steering_step_assert.svh"
module seek_steering_step (
  input  logic  clk_i,
  input  logic  rst_ni,
  sss_in_if.sink    in_s,
  sss_cfg_if.sink   cfg_s,
  sss_out_if.source out_m
);
  import sss_pkg::*;

  flow_t flow;
  logic  out_vld_q;
  logic [StepW-1:0] step_time_q;

  // pipeline moves whenever the output register is free or being taken
  assign flow.adv = !out_vld_q || out_m.ready;
  assign in_s.ready  = flow.adv;
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q <= StepTimeReset;
    end else if (cfg_s.valid) begin
      step_time_q <= cfg_s.data;
    end
  end

  // stage 1: deltas and travel product
  logic             v1_q;
  in_item_t         it1_q;
  logic signed [DeltaW-1:0] dx1_q, dy1_q, dz1_q;
  logic [TravW-1:0] trav1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (flow.adv) begin
      v1_q <= in_s.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (flow.adv) begin
      it1_q   <= in_s.data;
      dx1_q   <= DeltaW'(in_s.data.target_x) - DeltaW'(in_s.data.pos_x);
      dy1_q   <= DeltaW'(in_s.data.target_y) - DeltaW'(in_s.data.pos_y);
      dz1_q   <= DeltaW'(in_s.data.target_z) - DeltaW'(in_s.data.pos_z);
      trav1_q <= TravW'(in_s.data.speed) * TravW'(step_time_q);
    end
  end

  // stage 2: magnitudes and signs
  logic            v2_q;
  carry_t          c2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (flow.adv) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (flow.adv) begin
      c2_q.entity_index <= it1_q.entity_index;
      c2_q.pos_x        <= it1_q.pos_x;
      c2_q.pos_y        <= it1_q.pos_y;
      c2_q.pos_z        <= it1_q.pos_z;
      c2_q.target_x     <= it1_q.target_x;
      c2_q.target_y     <= it1_q.target_y;
      c2_q.target_z     <= it1_q.target_z;
      c2_q.speed        <= it1_q.speed;
      c2_q.snap_radius  <= it1_q.snap_radius;
      c2_q.neg_x <= dx1_q[DeltaW-1];
      c2_q.neg_y <= dy1_q[DeltaW-1];
      c2_q.neg_z <= dz1_q[DeltaW-1];
      c2_q.mag_x <= dx1_q[DeltaW-1] ? MagW'(-dx1_q) : MagW'(dx1_q);
      c2_q.mag_y <= dy1_q[DeltaW-1] ? MagW'(-dy1_q) : MagW'(dy1_q);
      c2_q.mag_z <= dz1_q[DeltaW-1] ? MagW'(-dz1_q) : MagW'(dz1_q);
      c2_q.travel <= trav1_q;
    end
  end

  // stage 3: squares, one multiplier per axis
  logic            v3_q;
  carry_t          c3_q;
  logic [SqW-1:0]  sqx3_q, sqy3_q, sqz3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (flow.adv) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (flow.adv) begin
      c3_q   <= c2_q;
      sqx3_q <= SqW'(c2_q.mag_x) * SqW'(c2_q.mag_x);
      sqy3_q <= SqW'(c2_q.mag_y) * SqW'(c2_q.mag_y);
      sqz3_q <= SqW'(c2_q.mag_z) * SqW'(c2_q.mag_z);
    end
  end

  // stage 4: sum of squares
  logic            v4_q;
  carry_t          c4_q;
  logic [SumW-1:0] sum4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (flow.adv) begin
      v4_q <= v3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (flow.adv) begin
      c4_q   <= c3_q;
      sum4_q <= SumW'(sqx3_q) + SumW'(sqy3_q) + SumW'(sqz3_q);
    end
  end

  // square root stages
  logic             vr;
  logic [RootW-1:0] root;
  carry_t           cr;
  sss_sqrt_pipe u_sqrt (
    .clk_i, .rst_ni, .flow_i(flow), .valid_i(v4_q), .sum_i(sum4_q),
    .carry_i(c4_q), .valid_o(vr), .root_o(root), .carry_o(cr)
  );

  // decision stage: arrival test and dividend products
  // the travel product is up to 51 bits, so the scaled root is widened to it
  logic             v5_q;
  carry_t           c5_q;
  logic             arr5_q;
  logic [RootW-1:0] dist5_q;
  logic [ProdW-1:0] px5_q, py5_q, pz5_q;
  logic             arr_now;
  assign arr_now = (root <= RootW'(cr.snap_radius)) ||
                   (TravW'({root, 16'h0}) <= cr.travel);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (flow.adv) begin
      v5_q <= vr;
    end
  end
  always_ff @(posedge clk_i) begin
    if (flow.adv) begin
      c5_q    <= cr;
      arr5_q  <= arr_now;
      // a zero root always arrives; use one so the divider stays defined
      dist5_q <= arr_now ? RootW'(1) : root;
      px5_q   <= ProdW'(cr.mag_x) * ProdW'(cr.speed);
      py5_q   <= ProdW'(cr.mag_y) * ProdW'(cr.speed);
      pz5_q   <= ProdW'(cr.mag_z) * ProdW'(cr.speed);
    end
  end

  // three dividers share the pipeline control; side data runs alongside
  logic [QuoW-1:0] qx, qy, qz;
  sss_div_pipe u_div_x (.clk_i, .flow_i(flow), .num_i(px5_q),
                        .den_i(dist5_q), .quo_o(qx));
  sss_div_pipe u_div_y (.clk_i, .flow_i(flow), .num_i(py5_q),
                        .den_i(dist5_q), .quo_o(qy));
  sss_div_pipe u_div_z (.clk_i, .flow_i(flow), .num_i(pz5_q),
                        .den_i(dist5_q), .quo_o(qz));

  logic              vd_q [DivSteps+1];
  carry_t            cd_q [DivSteps+1];
  logic              ad_q [DivSteps+1];
  always_comb begin
    vd_q[0] = v5_q;
    cd_q[0] = c5_q;
    ad_q[0] = arr5_q;
  end
  for (genvar s = 0; s < DivSteps; s++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[s+1] <= 1'b0;
      end else if (flow.adv) begin
        vd_q[s+1] <= vd_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (flow.adv) begin
        cd_q[s+1] <= cd_q[s];
        ad_q[s+1] <= ad_q[s];
      end
    end
  end

  // saturate and apply sign
  function automatic logic [PosW-1:0] sat_vel(input logic [QuoW-1:0] q, input logic neg);
    logic [PosW-1:0] r;
    if (neg) begin
      r = (q > QuoW'(33'h080000000)) ? PosW'(32'h80000000) : PosW'(-q);
    end else begin
      r = (q > QuoW'(32'h7FFFFFFF)) ? PosW'(32'h7FFFFFFF) : PosW'(q);
    end
    return r;
  endfunction

  carry_t     cf;
  logic       af;
  out_item_t  res_d, res_q;
  assign cf = cd_q[DivSteps];
  assign af = ad_q[DivSteps];
  always_comb begin
    res_d.out_entity_index = cf.entity_index;
    res_d.arrived          = af;
    res_d.new_pos_x = af ? cf.target_x : cf.pos_x;
    res_d.new_pos_y = af ? cf.target_y : cf.pos_y;
    res_d.new_pos_z = af ? cf.target_z : cf.pos_z;
    res_d.vel_x = af ? '0 : sat_vel(qx, cf.neg_x);
    res_d.vel_y = af ? '0 : sat_vel(qy, cf.neg_y);
    res_d.vel_z = af ? '0 : sat_vel(qz, cf.neg_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (flow.adv) begin
      out_vld_q <= vd_q[DivSteps];
    end
  end
  always_ff @(posedge clk_i) begin
    if (flow.adv) begin
      res_q <= res_d;
    end
  end

  assign out_m.valid = out_vld_q;
  assign out_m.data  = res_q;

  `SSS_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_vld_q && !out_m.ready,
                   out_vld_q && $stable(res_q))
  `SSS_ASSERT_ALWAYS(a_arrived_zero_vel, clk_i, rst_ni,
                     !(out_vld_q && res_q.arrived) ||
                     (res_q.vel_x == '0 && res_q.vel_y == '0 && res_q.vel_z == '0))
  `SSS_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_s.valid && in_s.ready, v1_q)
endmodule
